@@ hdl/focft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package focft_pkg;

   localparam int ANGLE_BITS_DEF = 12;

   localparam int MECH_W  = 12;
   localparam int ELEC_W  = 12;
   localparam int CUR_W   = 16;
   localparam int VOLT_W  = 16;
   localparam int SPEED_W = 22;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 104;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam int OFFSET_W = 12;
   localparam int POLES_W  = 5;
   localparam int LIMIT_W  = 15;
   localparam int SCALE_W  = 10;

   localparam logic [OFFSET_W-1:0] ANGLE_OFFSET_RST = 12'd260;
   localparam logic [POLES_W-1:0]  POLE_PAIRS_RST   = 5'd11;
   localparam logic [LIMIT_W-1:0]  VOLT_LIMIT_RST   = 15'd2560;
   localparam logic [SCALE_W-1:0]  SPEED_SCALE_RST  = 10'd15;

   // shared multiplier / accumulator
   localparam int MUL_W = 18;
   localparam int ACC_W = 40;
   localparam int Q15_SHIFT = 15;
   localparam logic signed [ACC_W-1:0] ROUND_Q15 = ACC_W'(1 << (Q15_SHIFT - 1));

   localparam int INV_SQRT3_Q15     = 18919;
   localparam int TWO_INV_SQRT3_Q15 = 37837;

   // quarter-wave sine table
   localparam int FRAC_W = 8;
   localparam int BIAS_W = 24;
   localparam int SINE_W = 16;
   localparam int QIDX_W = 7;
   localparam logic [QIDX_W-1:0] QWAVE_LAST = 7'd64;

   localparam logic [SINE_W-1:0] QWAVE [0:64] = '{
      16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
      16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
      16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
      16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
      16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
      16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
      16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
      16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
      16'd32767
   };

   localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] S22_MAX = ACC_W'((1 << 21) - 1);
   localparam logic signed [ACC_W-1:0] S22_MIN = -ACC_W'(1 << 21);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_ACCUM,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_ELEC,
      OP_SIN,
      OP_COS,
      OP_CLA,
      OP_CLB,
      OP_IDA,
      OP_IDB,
      OP_IQA,
      OP_IQB,
      OP_UAA,
      OP_UAB,
      OP_UBA,
      OP_UBB,
      OP_SPEED
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ANGLE_OFFSET = 2'd0,
      REG_POLE_PAIRS   = 2'd1,
      REG_VOLT_LIMIT   = 2'd2,
      REG_SPEED_SCALE  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic accum;
      logic load;
      logic sub;
   } mac_ctrl_type;

   typedef struct packed {
      logic [SINE_W-1:0] step;
      logic [FRAC_W-1:0] frac;
      logic [BIAS_W-1:0] bias;
      logic              neg;
   } sine_op_type;

   typedef struct packed {
      logic [3:0]               pad;
      logic signed [VOLT_W-1:0] volt_q;
      logic signed [VOLT_W-1:0] volt_d;
      logic signed [CUR_W-1:0]  phase_v;
      logic signed [CUR_W-1:0]  phase_u;
      logic [MECH_W-1:0]        mech_angle;
   } req_data_type;

   typedef struct packed {
      logic [5:0]                pad;
      logic signed [SPEED_W-1:0] speed_rpm;
      logic signed [VOLT_W-1:0]  volt_beta;
      logic signed [VOLT_W-1:0]  volt_alpha;
      logic signed [CUR_W-1:0]   axis_q;
      logic signed [CUR_W-1:0]   axis_d;
      logic [ELEC_W-1:0]         elec_angle;
   } rsp_data_type;

   function automatic logic [SINE_W-1:0] qwave(input logic [QIDX_W-1:0] idx);
      return (idx > QWAVE_LAST) ? QWAVE[QWAVE_LAST] : QWAVE[idx];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
      if (x > S16_MAX) begin
         return 16'sh7FFF;
      end else if (x < S16_MIN) begin
         return 16'sh8000;
      end
      return 16'(x);
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat22(input logic signed [ACC_W-1:0] x);
      if (x > S22_MAX) begin
         return SPEED_W'(S22_MAX);
      end else if (x < S22_MIN) begin
         return SPEED_W'(S22_MIN);
      end
      return SPEED_W'(x);
   endfunction

endpackage

`default_nettype wire

@@ hdl/foc_frame_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Field-oriented-control frame transform.
// req_* carries one control-period item: mechanical angle, phase currents U/V and
// the d/q voltage commands. rsp_* returns electrical angle, Id, Iq, U-alpha,
// U-beta and speed. csr_* writes angle_offset, pole_pairs, volt_limit and
// speed_scale (index 0..3); csr_ready is always high, write only while idle.
// All products go through one 18x18 multiplier with a registered product and a
// 40-bit accumulator. The sequencer runs 14 multiply steps, each an issue and an
// accumulate state: electrical angle, sine, cosine, Clarke, Park, inverse Park
// and speed. A new item is taken only after the previous one has left the
// sequencer; req_tready is high only in the idle state, between items.
// The result sits in an output register, so a new item is taken while a result
// waits; if the receiver stalls longer, the next result holds in the sequencer
// until the output register frees.
// Reset loads the default configuration and clears the previous angle to 0.

module foc_frame_transform import focft_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // mech_angle[11:0], phase_u[27:12], phase_v[43:28], volt_d[59:44],
   // volt_q[75:60], zero[79:76]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // elec_angle[11:0], axis_d[27:12], axis_q[43:28], volt_alpha[59:44],
   // volt_beta[75:60], speed_rpm[97:76], zero[103:98]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FRAC_BITS = ANGLE_BITS - 8;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      load_out;
   logic      req_accept;

   logic [OFFSET_W-1:0] angle_offset_ff;
   logic [POLES_W-1:0]  pole_pairs_ff;
   logic [LIMIT_W-1:0]  volt_limit_ff;
   logic [SCALE_W-1:0]  speed_scale_ff;

   req_data_type              req_data;
   logic [ANGLE_BITS-1:0]     mech_m;
   logic [ANGLE_BITS-1:0]     last_angle_ff;
   logic [ANGLE_BITS-1:0]     rel_ff;
   logic signed [ANGLE_BITS-1:0] diff_ff;
   logic signed [CUR_W-1:0]   iu_ff, iv_ff;
   logic signed [VOLT_W-1:0]  ud_ff, uq_ff;
   logic signed [VOLT_W-1:0]  ud_lim, uq_lim;
   logic signed [VOLT_W-1:0]  limit_s;

   logic [ANGLE_BITS-1:0]     elec_ff;
   logic [SINE_W-1:0]         s_mag_ff, c_mag_ff;
   logic                      s_neg_ff, c_neg_ff;
   logic signed [MUL_W-1:0]   ib_ff;
   logic signed [CUR_W-1:0]   id_ff, iq_ff;
   logic signed [VOLT_W-1:0]  ua_ff, ub_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   rsp_data_type              rsp_data_ff;

   logic [ANGLE_BITS-1:0]     sine_angle;
   sine_op_type               sine_op;
   mac_ctrl_type              mac_ctrl;
   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [MUL_W-1:0]   s_op, c_op;
   logic signed [ACC_W-1:0]   bias;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_shr;
   logic signed [ACC_W-1:0]   acc_frac;

   // input capture
   assign req_data   = req_tdata;
   assign req_accept = req_tvalid && req_tready;
   assign mech_m     = ANGLE_BITS'(req_data.mech_angle);
   assign limit_s    = signed'({1'b0, volt_limit_ff});
   assign ud_lim     = (req_data.volt_d >= limit_s) ? limit_s : req_data.volt_d;
   assign uq_lim     = (req_data.volt_q >= limit_s) ? limit_s : req_data.volt_q;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         iu_ff   <= req_data.phase_u;
         iv_ff   <= req_data.phase_v;
         ud_ff   <= ud_lim;
         uq_ff   <= uq_lim;
         rel_ff  <= mech_m - ANGLE_BITS'(angle_offset_ff);
         diff_ff <= signed'(mech_m - last_angle_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
      end else if (req_accept) begin
         last_angle_ff <= mech_m;
      end
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff <= ANGLE_OFFSET_RST;
         pole_pairs_ff   <= POLE_PAIRS_RST;
         volt_limit_ff   <= VOLT_LIMIT_RST;
         speed_scale_ff  <= SPEED_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_ANGLE_OFFSET: angle_offset_ff <= csr_wdata[OFFSET_W-1:0];
            REG_POLE_PAIRS:   pole_pairs_ff   <= csr_wdata[POLES_W-1:0];
            REG_VOLT_LIMIT:   volt_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_SPEED_SCALE:  speed_scale_ff  <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_ELEC;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      load_out   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_ISSUE;
               op_in    = OP_ELEC;
            end
         end
         ST_ISSUE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (op_ff == OP_SPEED) begin
               state_in = ST_DONE;
            end else begin
               op_in    = op_type'(op_ff + 4'd1);
               state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid_in = load_out || (rsp_tvalid_ff && !rsp_tready);

   // operand selection for the shared multiplier
   assign sine_angle = (op_ff == OP_COS) ? (elec_ff + QUARTER) : elec_ff;
   assign s_op       = MUL_W'(s_mag_ff);
   assign c_op       = MUL_W'(c_mag_ff);

   focft_sine #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_sine (
      .angle   (sine_angle),
      .sine_op (sine_op)
   );

   always_comb begin
      mac_ctrl.accum = (state_ff == ST_ACCUM);
      mac_ctrl.load  = 1'b1;
      mac_ctrl.sub   = 1'b0;
      op_a           = '0;
      op_b           = '0;
      bias           = '0;
      unique case (op_ff) inside
         OP_ELEC: begin
            op_a = MUL_W'(rel_ff);
            op_b = MUL_W'(pole_pairs_ff);
         end
         OP_SIN, OP_COS: begin
            op_a = MUL_W'(sine_op.step);
            op_b = MUL_W'(sine_op.frac);
            bias = ACC_W'(sine_op.bias);
         end
         OP_CLA: begin
            op_a = MUL_W'(iu_ff);
            op_b = MUL_W'(INV_SQRT3_Q15);
            bias = ROUND_Q15;
         end
         OP_CLB: begin
            mac_ctrl.load = 1'b0;
            op_a = MUL_W'(iv_ff);
            op_b = MUL_W'(TWO_INV_SQRT3_Q15);
         end
         OP_IDA: begin
            op_a = MUL_W'(iu_ff);
            op_b = c_op;
            mac_ctrl.sub = c_neg_ff;
            bias = ROUND_Q15;
         end
         OP_IDB: begin
            mac_ctrl.load = 1'b0;
            op_a = ib_ff;
            op_b = s_op;
            mac_ctrl.sub = s_neg_ff;
         end
         OP_IQA: begin
            op_a = ib_ff;
            op_b = c_op;
            mac_ctrl.sub = c_neg_ff;
            bias = ROUND_Q15;
         end
         OP_IQB: begin
            mac_ctrl.load = 1'b0;
            op_a = MUL_W'(iu_ff);
            op_b = s_op;
            mac_ctrl.sub = !s_neg_ff;
         end
         OP_UAA: begin
            op_a = MUL_W'(ud_ff);
            op_b = c_op;
            mac_ctrl.sub = c_neg_ff;
            bias = ROUND_Q15;
         end
         OP_UAB: begin
            mac_ctrl.load = 1'b0;
            op_a = MUL_W'(uq_ff);
            op_b = s_op;
            mac_ctrl.sub = !s_neg_ff;
         end
         OP_UBA: begin
            op_a = MUL_W'(ud_ff);
            op_b = s_op;
            mac_ctrl.sub = s_neg_ff;
            bias = ROUND_Q15;
         end
         OP_UBB: begin
            mac_ctrl.load = 1'b0;
            op_a = MUL_W'(uq_ff);
            op_b = c_op;
            mac_ctrl.sub = c_neg_ff;
         end
         OP_SPEED: begin
            op_a = MUL_W'(diff_ff);
            op_b = MUL_W'(speed_scale_ff);
            mac_ctrl.sub = 1'b1;
         end
         default: ;
      endcase
   end

   focft_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (op_a),
      .op_b   (op_b),
      .bias   (bias),
      .acc_in (acc_in)
   );

   // result capture
   assign acc_shr  = acc_in >>> Q15_SHIFT;
   assign acc_frac = acc_in >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (state_ff == ST_ACCUM) begin
         case (op_ff)
            OP_ELEC:  elec_ff  <= acc_in[ANGLE_BITS-1:0];
            OP_SIN: begin
               s_mag_ff <= acc_frac[SINE_W-1:0];
               s_neg_ff <= sine_op.neg;
            end
            OP_COS: begin
               c_mag_ff <= acc_frac[SINE_W-1:0];
               c_neg_ff <= sine_op.neg;
            end
            OP_CLB:   ib_ff    <= acc_shr[MUL_W-1:0];
            OP_IDB:   id_ff    <= sat16(acc_shr);
            OP_IQB:   iq_ff    <= sat16(acc_shr);
            OP_UAB:   ua_ff    <= sat16(acc_shr);
            OP_UBB:   ub_ff    <= sat16(acc_shr);
            OP_SPEED: speed_ff <= sat22(acc_in);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.pad        <= '0;
         rsp_data_ff.speed_rpm  <= speed_ff;
         rsp_data_ff.volt_beta  <= ub_ff;
         rsp_data_ff.volt_alpha <= ua_ff;
         rsp_data_ff.axis_q     <= iq_ff;
         rsp_data_ff.axis_d     <= id_ff;
         rsp_data_ff.elec_angle <= ELEC_W'(elec_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ISSUE && op_ff == OP_ELEC))
      else $error("accepted item did not start the sequence");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside of the done step");

   a_issue_accum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |=> (state_ff == ST_ACCUM && $stable(op_ff)))
      else $error("multiply step not followed by its accumulate");

endmodule

`default_nettype wire

@@ hdl/focft_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module focft_mac import focft_pkg::*; (
   input  wire logic                    clock,
   input  wire mac_ctrl_type            ctrl,
   input  wire logic signed [MUL_W-1:0] op_a,
   input  wire logic signed [MUL_W-1:0] op_b,
   input  wire logic signed [ACC_W-1:0] bias,
   output logic signed [ACC_W-1:0]      acc_in
);

   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   base;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctrl.accum) begin
         acc_ff <= acc_in;
      end
   end

   assign prod_ext = ACC_W'(prod_ff);
   assign base     = ctrl.load ? bias : acc_ff;
   assign acc_in   = ctrl.sub ? (base - prod_ext) : (base + prod_ext);

endmodule

`default_nettype wire

@@ hdl/focft_sine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module focft_sine import focft_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic [ANGLE_BITS-1:0] angle,
   output sine_op_type                sine_op
);

   localparam int FRAC_BITS = ANGLE_BITS - 8;
   localparam int HALF      = (1 << FRAC_BITS) >> 1;
   localparam logic [ANGLE_BITS-2:0] QUARTER   = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-2:0] FRAC_MASK = (ANGLE_BITS-1)'((1 << FRAC_BITS) - 1);

   logic [1:0]            quad;
   logic [ANGLE_BITS-2:0] pos;
   logic [ANGLE_BITS-2:0] x;
   logic [QIDX_W-1:0]     idx;
   logic [QIDX_W-1:0]     idx_next;
   logic [SINE_W-1:0]     base_val;

   assign quad     = angle[ANGLE_BITS-1:ANGLE_BITS-2];
   assign pos      = {1'b0, angle[ANGLE_BITS-3:0]};
   assign x        = quad[0] ? (QUARTER - pos) : pos;
   assign idx      = QIDX_W'(x >> FRAC_BITS);
   assign idx_next = (idx >= QWAVE_LAST) ? QWAVE_LAST : (idx + 7'd1);
   assign base_val = qwave(idx);

   assign sine_op.step = qwave(idx_next) - base_val;
   assign sine_op.frac = FRAC_W'(x & FRAC_MASK);
   assign sine_op.bias = (BIAS_W'(base_val) << FRAC_BITS) + BIAS_W'(HALF);
   assign sine_op.neg  = quad[1];

endmodule

`default_nettype wire
